// ===== design/cpm_pkg.sv =====
// ----------------------------------------------------------------------------
// cpm_pkg - shared definitions for the CIDR prefix list matcher
// Field widths, command codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package cpm_pkg;

  localparam int CMD_W           = 2;
  localparam int ADDR_W          = 32;
  localparam int LEN_W           = 6;
  localparam int ENTRY_W         = 2 * ADDR_W;   // {mask, subnet}
  localparam int IN_TDATA_W      = 40;           // address + prefix_len, byte padded
  localparam int OUT_TDATA_W     = 8;            // match + status, byte padded
  localparam int TABLE_DEPTH_DEF = 64;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the input transaction
    logic exec;      // run clear / append / scan set-up
    logic scan;      // one scan step
    logic out_load;  // move the result into the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_lookup;
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/cpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpm_ctrl - sequencing for the CIDR prefix list matcher
// Accepts one transaction, runs it in the datapath, hands the result over.
// ----------------------------------------------------------------------------
module cpm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  cpm_pkg::dp_stat_t    stat,
  output cpm_pkg::ctrl_cmd_t   ctrl
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    ctrl          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ctrl.load = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctrl.exec = 1'b1;
        state_nxt = stat.is_lookup ? ST_SCAN : ST_RESP;
      end
      ST_SCAN: begin
        ctrl.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/cpm_dpath.sv =====
// ----------------------------------------------------------------------------
// cpm_dpath - prefix store, scan compare and result register
// Holds the entry memory and count, builds masks, scans entries in order.
// ----------------------------------------------------------------------------
module cpm_dpath #(
  parameter int TABLE_DEPTH = cpm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [cpm_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [cpm_pkg::CMD_W-1:0]         in_tuser,
  input  cpm_pkg::ctrl_cmd_t                ctrl,
  output cpm_pkg::dp_stat_t                 stat,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cpm_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int AW    = cpm_pkg::ADDR_W;

  // captured transaction
  logic [cpm_pkg::CMD_W-1:0] cmd_r;
  logic [AW-1:0]             addr_r;
  logic [cpm_pkg::LEN_W-1:0] len_r;

  logic [CNT_W-1:0] count_r,  count_nxt;
  logic [CNT_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic             rvalid_r, rvalid_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             res_match_r,  res_match_nxt;
  logic             res_status_r, res_status_nxt;
  logic             out_match_r;
  logic             out_status_r;

  logic [cpm_pkg::ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [cpm_pkg::ENTRY_W-1:0] rdata_r;

  logic          full;
  logic [AW-1:0] mask;
  logic          rd_en;
  logic          wr_en;
  logic          more;
  logic [AW-1:0] sub_q;
  logic [AW-1:0] mask_q;
  logic          zero_sub;
  logic          hit;

  assign full   = (count_r >= CNT_W'(TABLE_DEPTH));
  // lengths 32..63 saturate to all ones; /0 gives an empty mask
  assign mask   = len_r[5] ? '1 : ~({AW{1'b1}} >> len_r[4:0]);
  assign more   = (rd_ptr_r < count_r);
  assign rd_en  = ctrl.scan && more;
  assign wr_en  = ctrl.exec && (cmd_r == cpm_pkg::CMD_APPEND) && !full;

  assign sub_q    = rdata_r[AW-1:0];
  assign mask_q   = rdata_r[cpm_pkg::ENTRY_W-1:AW];
  assign zero_sub = (sub_q == '0);
  assign hit      = ((mask_q & addr_r) == sub_q);

  assign stat.is_lookup = (cmd_r == cpm_pkg::CMD_LOOKUP);
  // an entry in flight is judged first; with none, the scan ends at the count
  assign stat.scan_done = rvalid_r ? (zero_sub || hit) : !more;
  assign stat.out_free  = !out_valid_r || out_tready;

  always_comb begin
    count_nxt      = count_r;
    rd_ptr_nxt     = rd_ptr_r;
    rvalid_nxt     = rvalid_r;
    res_match_nxt  = res_match_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.out_load) begin
      out_valid_nxt = 1'b1;
    end

    if (ctrl.exec) begin
      res_match_nxt  = 1'b0;
      res_status_nxt = 1'b0;
      rd_ptr_nxt     = '0;
      rvalid_nxt     = 1'b0;
      case (cmd_r)
        cpm_pkg::CMD_CLEAR: begin
          count_nxt = '0;
        end
        cpm_pkg::CMD_APPEND: begin
          if (full) begin
            res_status_nxt = 1'b1;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (ctrl.scan) begin
      rvalid_nxt = rd_en;
      if (rd_en) begin
        rd_ptr_nxt = rd_ptr_r + 1'b1;
      end
      if (stat.scan_done) begin
        res_match_nxt = rvalid_r && !zero_sub && hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_ptr_r    <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_match_r  <= res_match_nxt;
    res_status_r <= res_status_nxt;
    if (ctrl.load) begin
      cmd_r  <= in_tuser;
      addr_r <= in_tdata[AW-1:0];
      len_r  <= in_tdata[AW+cpm_pkg::LEN_W-1:AW];
    end
    if (ctrl.out_load) begin
      out_match_r  <= res_match_r;
      out_status_r <= res_status_r;
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= {mask, addr_r & mask};
    end
    if (rd_en) begin
      rdata_r <= mem[rd_ptr_r[IDX_W-1:0]];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(cpm_pkg::OUT_TDATA_W-2){1'b0}}, out_status_r, out_match_r};

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |-> (!out_valid_r || out_tready))
    else $error("result loaded over an untaken result");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (rd_ptr_r < count_r))
    else $error("scan read past the last entry");

  a_status_append_only: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.out_load && (cmd_r != cpm_pkg::CMD_APPEND)) |-> !res_status_r)
    else $error("status raised outside an append");
`endif

endmodule

// ===== design/cidr_prefix_list_match.sv =====
// ----------------------------------------------------------------------------
// cidr_prefix_list_match - IPv4 address filter over a list of CIDR prefixes
// Clear, append and lookup commands over a stored list of subnet/mask entries.
// ----------------------------------------------------------------------------
// One transaction is handled at a time and each gives exactly one result.
// A clear or append goes from acceptance through the execute state to the
// response state, which loads the result once the output register is free; a
// lookup scans the entries in order in between, until the fill count or
// a verdict, because the prefix memory has one read port and is read one entry
// per cycle. The next transaction is accepted in the cycle after the previous
// result is loaded into the output register, even if it is not yet taken.
// The command sits in in_tuser; address and prefix length in in_tdata.
// ----------------------------------------------------------------------------
module cidr_prefix_list_match #(
  parameter int TABLE_DEPTH = cpm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] address, [37:32] prefix_len, [39:38] zero
  input  logic [cpm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] command
  input  logic [cpm_pkg::CMD_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] match, [1] status, [7:2] zero
  output logic [cpm_pkg::OUT_TDATA_W-1:0] out_tdata
);

  cpm_pkg::ctrl_cmd_t ctrl;
  cpm_pkg::dp_stat_t  stat;

  cpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  cpm_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
